FILE: rtl/pngcw_pkg.sv
`default_nettype none
package pngcw_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] chunk_offset;
    logic [30:0] chunk_length;
    logic [31:0] chunk_crc;
    logic [15:0] idat_count;
    logic        last;
  } out_item_t;

  // Up to two result items caused by one input byte.
  typedef struct packed {
    logic [1:0] n;
    out_item_t  first;
    out_item_t  second;
  } res_pair_t;

  typedef enum logic [3:0] {
    PH_SIG       = 4'd0,
    PH_SIG_BAD   = 4'd1,
    PH_IHDR_HDR  = 4'd2,
    PH_IHDR_DATA = 4'd3,
    PH_IHDR_CRC  = 4'd4,
    PH_HDR       = 4'd5,
    PH_DATA      = 4'd6,
    PH_CRC       = 4'd7,
    PH_DONE      = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    EV_SIG_OK       = 3'd0,
    EV_SIG_BAD      = 3'd1,
    EV_IHDR_OK      = 3'd2,
    EV_IHDR_MISSING = 3'd3,
    EV_IDAT_FOUND   = 3'd4,
    EV_IEND_FOUND   = 3'd5,
    EV_IEND_MISSING = 3'd6
  } event_t;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  localparam logic [7:0] SIG_BYTES [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};

  localparam logic [15:0] IDAT_MAX = 16'hFFFF;

endpackage
`default_nettype wire

FILE: rtl/pngcw_core.sv
`default_nettype none
module pngcw_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire pngcw_pkg::in_item_t item,
  output pngcw_pkg::res_pair_t     res
);

  pngcw_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  fbi_r, fbi_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] start_r, start_nxt;
  logic [15:0] idat_r, idat_nxt;

  logic [31:0] hdr_len, hdr_type, hdr_start, skip_dec;
  logic [7:0]  b;
  logic        live, prim_v, eos_v;
  pngcw_pkg::event_t prim_ev, eos_ev;
  logic [31:0] prim_off, prim_crc;
  logic [30:0] prim_len;
  pngcw_pkg::out_item_t prim_item, eos_item;

  assign b         = item.data_byte;
  assign hdr_len   = (fbi_r < 3'd4) ? {len_r[23:0], b} : len_r;
  assign hdr_type  = (fbi_r >= 3'd4) ? {type_r[23:0], b} : type_r;
  assign hdr_start = (fbi_r == 3'd0) ? offset_r : start_r;
  assign skip_dec  = skip_r - 32'd1;

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    fbi_nxt    = fbi_r;
    offset_nxt = offset_r;
    len_nxt    = len_r;
    type_nxt   = type_r;
    crc_nxt    = crc_r;
    skip_nxt   = skip_r;
    start_nxt  = start_r;
    idat_nxt   = idat_r;
    live       = 1'b0;
    prim_v     = 1'b0;
    prim_ev    = pngcw_pkg::EV_SIG_OK;
    prim_off   = '0;
    prim_len   = '0;
    prim_crc   = '0;
    eos_v      = 1'b0;
    eos_ev     = pngcw_pkg::EV_IEND_MISSING;
    if (fire) begin
      unique case (phase_r)
        pngcw_pkg::PH_SIG, pngcw_pkg::PH_SIG_BAD: begin
          live    = 1'b1;
          fbi_nxt = fbi_r + 3'd1;
          if (phase_r == pngcw_pkg::PH_SIG && b != pngcw_pkg::SIG_BYTES[fbi_r]) begin
            phase_nxt = pngcw_pkg::PH_SIG_BAD;
          end
          if (fbi_r == 3'd7) begin
            prim_v = 1'b1;
            if (phase_nxt == pngcw_pkg::PH_SIG) begin
              prim_ev   = pngcw_pkg::EV_SIG_OK;
              phase_nxt = pngcw_pkg::PH_IHDR_HDR;
            end else begin
              prim_ev   = pngcw_pkg::EV_SIG_BAD;
              phase_nxt = pngcw_pkg::PH_DONE;
            end
          end
        end
        pngcw_pkg::PH_IHDR_HDR, pngcw_pkg::PH_HDR: begin
          live      = 1'b1;
          len_nxt   = hdr_len;
          type_nxt  = hdr_type;
          start_nxt = hdr_start;
          fbi_nxt   = fbi_r + 3'd1;
          if (fbi_r == 3'd7) begin
            if (phase_r == pngcw_pkg::PH_IHDR_HDR && hdr_type != pngcw_pkg::TYPE_IHDR) begin
              prim_v    = 1'b1;
              prim_ev   = pngcw_pkg::EV_IHDR_MISSING;
              phase_nxt = pngcw_pkg::PH_DONE;
            end else if (phase_r == pngcw_pkg::PH_HDR &&
                         hdr_type == pngcw_pkg::TYPE_IEND) begin
              prim_v    = 1'b1;
              prim_ev   = pngcw_pkg::EV_IEND_FOUND;
              prim_off  = hdr_start;
              prim_len  = hdr_len[30:0];
              phase_nxt = pngcw_pkg::PH_DONE;
            end else begin
              if (phase_r == pngcw_pkg::PH_IHDR_HDR) begin
                prim_v   = 1'b1;
                prim_ev  = pngcw_pkg::EV_IHDR_OK;
                prim_off = hdr_start;
                prim_len = hdr_len[30:0];
              end
              // enter the data section; empty chunks go straight to the CRC
              crc_nxt = '0;
              if (hdr_len == 32'd0) begin
                phase_nxt = (phase_r == pngcw_pkg::PH_HDR) ? pngcw_pkg::PH_CRC
                                                           : pngcw_pkg::PH_IHDR_CRC;
              end else begin
                skip_nxt  = hdr_len;
                phase_nxt = (phase_r == pngcw_pkg::PH_HDR) ? pngcw_pkg::PH_DATA
                                                           : pngcw_pkg::PH_IHDR_DATA;
              end
            end
          end
        end
        pngcw_pkg::PH_IHDR_DATA, pngcw_pkg::PH_DATA: begin
          live     = 1'b1;
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            phase_nxt = (phase_r == pngcw_pkg::PH_DATA) ? pngcw_pkg::PH_CRC
                                                        : pngcw_pkg::PH_IHDR_CRC;
          end
        end
        pngcw_pkg::PH_IHDR_CRC, pngcw_pkg::PH_CRC: begin
          live    = 1'b1;
          crc_nxt = {crc_r[23:0], b};
          fbi_nxt = {1'b0, fbi_r[1:0] + 2'd1};
          if (fbi_r[1:0] == 2'd3) begin
            if (phase_r == pngcw_pkg::PH_CRC && type_r == pngcw_pkg::TYPE_IDAT) begin
              if (idat_r != pngcw_pkg::IDAT_MAX) begin
                idat_nxt = idat_r + 16'd1;
              end
              prim_v   = 1'b1;
              prim_ev  = pngcw_pkg::EV_IDAT_FOUND;
              prim_off = start_r;
              prim_len = len_r[30:0];
              prim_crc = {crc_r[23:0], b};
            end
            phase_nxt = pngcw_pkg::PH_HDR;
          end
        end
        default: begin
          // finished, or an unused code: bytes are dropped
          live = 1'b0;
        end
      endcase

      if (live) begin
        offset_nxt = offset_r + 32'd1;
        if (item.end_of_stream) begin
          if (phase_nxt != pngcw_pkg::PH_DONE) begin
            eos_v = 1'b1;
            if (phase_nxt == pngcw_pkg::PH_SIG || phase_nxt == pngcw_pkg::PH_SIG_BAD) begin
              eos_ev = pngcw_pkg::EV_SIG_BAD;
            end else if (phase_nxt == pngcw_pkg::PH_IHDR_HDR) begin
              eos_ev = pngcw_pkg::EV_IHDR_MISSING;
            end else begin
              eos_ev = pngcw_pkg::EV_IEND_MISSING;
            end
          end
          phase_nxt = pngcw_pkg::PH_DONE;
        end
      end
    end
  end

  // Result items
  always_comb begin
    prim_item.event_res    = prim_ev;
    prim_item.chunk_offset = prim_off;
    prim_item.chunk_length = prim_len;
    prim_item.chunk_crc    = prim_crc;
    prim_item.idat_count   = idat_nxt;
    prim_item.last         = ~eos_v;

    eos_item.event_res    = eos_ev;
    eos_item.chunk_offset = '0;
    eos_item.chunk_length = '0;
    eos_item.chunk_crc    = '0;
    eos_item.idat_count   = idat_nxt;
    eos_item.last         = 1'b1;

    res.n      = {1'b0, prim_v} + {1'b0, eos_v};
    res.first  = prim_v ? prim_item : eos_item;
    res.second = eos_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pngcw_pkg::PH_SIG;
      fbi_r    <= '0;
      offset_r <= '0;
      len_r    <= '0;
      type_r   <= '0;
      crc_r    <= '0;
      skip_r   <= '0;
      start_r  <= '0;
      idat_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      fbi_r    <= fbi_nxt;
      offset_r <= offset_nxt;
      len_r    <= len_nxt;
      type_r   <= type_nxt;
      crc_r    <= crc_nxt;
      skip_r   <= skip_nxt;
      start_r  <= start_nxt;
      idat_r   <= idat_nxt;
    end
  end

  a_done_sticks: assert property (@(posedge clk)
    (rst_n && phase_r == pngcw_pkg::PH_DONE) |=> (!$past(rst_n) || phase_r == pngcw_pkg::PH_DONE))
    else $error("parser left the finished phase without reset");

  a_pair_second_is_eos: assert property (@(posedge clk) disable iff (!rst_n)
    (res.n == 2'd2) |-> (res.second.event_res == pngcw_pkg::EV_IHDR_MISSING ||
                         res.second.event_res == pngcw_pkg::EV_IEND_MISSING))
    else $error("second result of a byte is not a stream-end event");

endmodule
`default_nettype wire

FILE: rtl/pngcw_outq.sv
`default_nettype none
module pngcw_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pngcw_pkg::res_pair_t push,
  output logic                      full,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pngcw_pkg::out_item_t      out_item
);

  pngcw_pkg::out_item_t q_r [3];
  pngcw_pkg::out_item_t q_nxt [3];
  pngcw_pkg::out_item_t sh [3];
  logic [1:0] count_r, count_nxt, cnt_pop;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign out_item  = q_r[0];
  assign pop       = out_valid && !out_stall;
  // room for a two-result byte is guaranteed while at most one item waits
  assign full      = (count_r > 2'd1);

  always_comb begin
    cnt_pop = count_r - {1'b0, pop};
    if (pop) begin
      sh[0] = q_r[1];
      sh[1] = q_r[2];
      sh[2] = q_r[2];
    end else begin
      sh[0] = q_r[0];
      sh[1] = q_r[1];
      sh[2] = q_r[2];
    end
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = sh[i];
      if (2'(i) == cnt_pop && push.n != 2'd0) begin
        q_nxt[i] = push.first;
      end else if (2'(i) == cnt_pop + 2'd1 && push.n == 2'd2) begin
        q_nxt[i] = push.second;
      end
    end
    count_nxt = cnt_pop + push.n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> (count_r <= 2'd1))
    else $error("result pushed into a full queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd0 && !pop) |=> (count_r == $past(count_r)))
    else $error("queue count changed with no push or pop");

endmodule
`default_nettype wire

FILE: rtl/png_chunk_walker.sv
`default_nettype none
// PNG chunk walker. Takes a PNG file one byte per item (end_of_stream on the last
// byte), checks the 8-byte signature, requires IHDR as the first chunk (both outcomes
// reported), then walks the chunk list and reports each IDAT (offset of its length
// field, data length, captured CRC - not verified), IEND with the IDAT count, or the
// error that stops the walk. A byte is taken every cycle unless in_stall is high:
// all parsing for it happens between the input and a 3-entry result queue. A byte
// yields zero, one or two result items, two when the stream ends right after a
// reported event. in_stall rises while two or more results wait in the queue, so the
// sustained rate is one byte per cycle as long as the sink drains results. After IEND,
// an error or the end of the stream, bytes are accepted and dropped until reset.
module png_chunk_walker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pngcw_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pngcw_pkg::out_item_t      out_item
);

  logic                in_fire;
  logic                q_full;
  pngcw_pkg::res_pair_t res;

  assign in_stall = q_full;
  assign in_fire  = in_valid && !q_full;

  // byte parser: chunk state and per-byte results
  pngcw_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .item  (in_item),
    .res   (res)
  );

  // result queue decouples the parser from the sink
  pngcw_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

FILE: tb/sv/png_chunk_walker_checker.sv
`default_nettype none
module png_chunk_walker_checker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire pngcw_pkg::in_item_t  in_item,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire pngcw_pkg::out_item_t out_item,
  output int                        mismatches,
  output int                        awaited
);
  import pngcw_pkg::*;

  // Shadow copy of the walker state.
  phase_t      ph;
  logic [2:0]  fld_idx;
  logic [31:0] byte_pos;
  logic [31:0] len_word;
  logic [31:0] type_word;
  logic [31:0] crc_word;
  logic [31:0] skip_left;
  logic [31:0] chunk_pos;
  logic [15:0] idat_seen;

  out_item_t pending_events [$];
  int        err_count = 0;
  int        event_idx = 0;

  function automatic out_item_t make_event(event_t ev, logic [31:0] off, logic [31:0] len,
                                           logic [31:0] crc);
    out_item_t r;
    r.event_res    = ev;
    r.chunk_offset = off;
    r.chunk_length = len[30:0];
    r.chunk_crc    = crc;
    r.idat_count   = idat_seen;
    r.last         = 1'b0;
    return r;
  endfunction

  // Length then type, both big-endian; true once all 8 header bytes are in.
  function automatic logic shift_header(logic [7:0] b);
    if (fld_idx == 3'd0) chunk_pos = byte_pos;
    if (fld_idx < 3'd4) len_word = {len_word[23:0], b};
    else type_word = {type_word[23:0], b};
    fld_idx = fld_idx + 3'd1;
    return fld_idx == 3'd0;
  endfunction

  task automatic start_body(phase_t data_ph, phase_t crc_ph);
    fld_idx  = 3'd0;
    crc_word = 32'd0;
    if (len_word == 32'd0) begin
      ph = crc_ph;
    end else begin
      skip_left = len_word;
      ph        = data_ph;
    end
  endtask

  task automatic walk_byte(logic [7:0] b, logic eos);
    out_item_t res [2];
    int        n;
    event_t    tail_ev;
    n = 0;
    if (ph == PH_DONE) return;
    case (ph)
      PH_SIG, PH_SIG_BAD: begin
        if (ph == PH_SIG && b != SIG_BYTES[fld_idx]) ph = PH_SIG_BAD;
        fld_idx = fld_idx + 3'd1;
        if (fld_idx == 3'd0) begin
          if (ph == PH_SIG) begin
            res[n] = make_event(EV_SIG_OK, 32'd0, 32'd0, 32'd0);
            ph = PH_IHDR_HDR;
          end else begin
            res[n] = make_event(EV_SIG_BAD, 32'd0, 32'd0, 32'd0);
            ph = PH_DONE;
          end
          n++;
        end
      end
      PH_IHDR_HDR: begin
        if (shift_header(b)) begin
          if (type_word == TYPE_IHDR) begin
            res[n] = make_event(EV_IHDR_OK, chunk_pos, len_word, 32'd0);
            start_body(PH_IHDR_DATA, PH_IHDR_CRC);
          end else begin
            res[n] = make_event(EV_IHDR_MISSING, 32'd0, 32'd0, 32'd0);
            ph = PH_DONE;
          end
          n++;
        end
      end
      PH_HDR: begin
        if (shift_header(b)) begin
          if (type_word == TYPE_IEND) begin
            res[n] = make_event(EV_IEND_FOUND, chunk_pos, len_word, 32'd0);
            n++;
            ph = PH_DONE;
          end else begin
            start_body(PH_DATA, PH_CRC);
          end
        end
      end
      PH_IHDR_DATA, PH_DATA: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 32'd0) ph = (ph == PH_DATA) ? PH_CRC : PH_IHDR_CRC;
      end
      default: begin
        crc_word = {crc_word[23:0], b};
        fld_idx  = {1'b0, fld_idx[1:0] + 2'd1};
        if (fld_idx == 3'd0) begin
          if (ph == PH_CRC && type_word == TYPE_IDAT) begin
            if (idat_seen != IDAT_MAX) idat_seen = idat_seen + 16'd1;
            res[n] = make_event(EV_IDAT_FOUND, chunk_pos, len_word, crc_word);
            n++;
          end
          ph = PH_HDR;
        end
      end
    endcase
    byte_pos = byte_pos + 32'd1;
    // stream end on an unfinished walk adds one closing event
    if (eos && ph != PH_DONE) begin
      if (ph == PH_SIG || ph == PH_SIG_BAD) tail_ev = EV_SIG_BAD;
      else if (ph == PH_IHDR_HDR) tail_ev = EV_IHDR_MISSING;
      else tail_ev = EV_IEND_MISSING;
      res[n] = make_event(tail_ev, 32'd0, 32'd0, 32'd0);
      n++;
    end
    if (eos) ph = PH_DONE;
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_events.push_back(res[i]);
  endtask

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (err_count < 100)
      $display("MISMATCH event %0d %s: expected %0h, got %0h", event_idx, what, want, got);
    err_count++;
  endtask

  task automatic check_event(out_item_t got);
    out_item_t want;
    if (pending_events.size() == 0) begin
      report_mismatch("unexpected event_res", 32'd0, 32'(got.event_res));
    end else begin
      want = pending_events.pop_front();
      if (got.event_res != want.event_res)
        report_mismatch("event_res", 32'(want.event_res), 32'(got.event_res));
      if (got.chunk_offset != want.chunk_offset)
        report_mismatch("chunk_offset", want.chunk_offset, got.chunk_offset);
      if (got.chunk_length != want.chunk_length)
        report_mismatch("chunk_length", 32'(want.chunk_length), 32'(got.chunk_length));
      if (got.chunk_crc != want.chunk_crc)
        report_mismatch("chunk_crc", want.chunk_crc, got.chunk_crc);
      if (got.idat_count != want.idat_count)
        report_mismatch("idat_count", 32'(want.idat_count), 32'(got.idat_count));
      if (got.last != want.last)
        report_mismatch("last", 32'(want.last), 32'(got.last));
    end
    event_idx++;
  endtask

  // Input side first: a same-cycle result would still find its expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      ph        = PH_SIG;
      fld_idx   = 3'd0;
      byte_pos  = 32'd0;
      len_word  = 32'd0;
      type_word = 32'd0;
      crc_word  = 32'd0;
      skip_left = 32'd0;
      chunk_pos = 32'd0;
      idat_seen = 16'd0;
      pending_events.delete();
    end else begin
      if (in_valid && !in_stall) walk_byte(in_item.data_byte, in_item.end_of_stream);
      if (out_valid && !out_stall) check_event(out_item);
    end
    awaited    <= pending_events.size();
    mismatches <= err_count;
  end

endmodule
`default_nettype wire

FILE: tb/sv/png_chunk_walker_tb.sv
`default_nettype none
module png_chunk_walker_tb;
  import pngcw_pkg::*;

  localparam int BYTES_WANTED = 750;     // random stream keeps going until both are met
  localparam int IDAT_WANTED  = 12;
  localparam int HOLD_START   = 300;     // earliest cycle at which the sink stops draining
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  // How the single file of the run is closed off.
  typedef enum int {
    END_IEND,      // IEND chunk header, sometimes followed by bytes that get dropped
    END_IDAT_EOS,  // stream end on the last CRC byte of an IDAT: two events from one byte
    END_LONG_CUT,  // chunk with a huge length word, cut short in its data
    END_HDR_CUT    // stream end somewhere inside a chunk header
  } ending_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int mismatches;
  int awaited;
  int cycle_cnt  = 0;
  int bytes_sent = 0;
  int idat_sent  = 0;
  int burst_left = 0;

  logic [7:0] chunk_bytes [$];   // bytes staged for the next chunk

  png_chunk_walker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  png_chunk_walker_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always #5 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte and hold it until the walker takes it. Valid only drops
  // when a gap is inserted, so back-to-back items keep it high.
  task automatic send_byte(logic [7:0] b, logic eos);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= {b, eos};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Send the staged bytes; with eos_at >= 0 the stream ends on that byte.
  task automatic send_staged(int eos_at);
    for (int i = 0; i < chunk_bytes.size() && (eos_at < 0 || i <= eos_at); i++)
      send_byte(chunk_bytes[i], i == eos_at);
    chunk_bytes.delete();
  endtask

  task automatic push_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) chunk_bytes.push_back(w[8*i +: 8]);
  endtask

  // Full chunk: length, type, random data, random CRC.
  task automatic build_chunk(logic [31:0] len, logic [31:0] ctype);
    push_word(len);
    push_word(ctype);
    repeat (len) chunk_bytes.push_back(8'($urandom));
    push_word($urandom);
  endtask

  // Sink: random short stalls, some long ones, some stretches that never stall,
  // and one long hold-off so the result queue fills and the input backs up.
  initial begin : sink
    int shut_n;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && cycle_cnt >= HOLD_START) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 15) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(40, 120)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        shut_n = pick_gap();
        if (shut_n > 0) begin
          out_stall <= 1'b1;
          repeat (shut_n) @(posedge clk);
        end
      end
    end
  end

  // Source: one PNG-shaped file for the whole run, since reset is applied once.
  initial begin : source
    logic [31:0] len_w;
    logic [31:0] type_w;
    int          r;
    int          n_tail;
    ending_t     ending;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed head: good signature, a zero-length IHDR whose CRC carries the
    // byte extremes, then a zero-length IDAT with an all-ones CRC.
    foreach (SIG_BYTES[i]) chunk_bytes.push_back(SIG_BYTES[i]);
    push_word(32'd0);
    push_word(TYPE_IHDR);
    push_word(32'h00FF_807F);
    push_word(32'd0);
    push_word(TYPE_IDAT);
    push_word(32'hFFFF_FFFF);
    idat_sent++;
    send_staged(-1);

    // Random chunk walk: mostly IDAT, plus ancillary and near-miss types.
    while (bytes_sent < BYTES_WANTED || idat_sent < IDAT_WANTED) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        type_w = TYPE_IDAT;
      end else if (r < 85) begin
        type_w = $urandom;
        if (type_w == TYPE_IDAT || type_w == TYPE_IEND) type_w ^= 32'h20;
      end else begin
        // one flipped bit away from IDAT or IEND
        type_w = ($urandom_range(0, 1) ? TYPE_IDAT : TYPE_IEND) ^ (32'h1 << $urandom_range(0, 31));
      end
      r = $urandom_range(0, 99);
      if (r < 25) len_w = 32'd0;
      else if (r < 85) len_w = $urandom_range(1, 16);
      else if (r < 97) len_w = $urandom_range(17, 64);
      else len_w = $urandom_range(65, 200);
      build_chunk(len_w, type_w);
      if (type_w == TYPE_IDAT) idat_sent++;
      send_staged(-1);
    end

    ending = ending_t'($urandom_range(0, 3));
    case (ending)
      END_IEND: begin
        // arbitrary length word: its top bit must not reach chunk_length
        push_word($urandom);
        push_word(TYPE_IEND);
        if ($urandom_range(0, 1)) begin
          send_staged(7);
        end else begin
          n_tail = $urandom_range(1, 12);
          repeat (n_tail) chunk_bytes.push_back(8'($urandom));
          send_staged(7 + n_tail);
        end
      end
      END_IDAT_EOS: begin
        build_chunk($urandom_range(0, 8), TYPE_IDAT);
        send_staged(chunk_bytes.size() - 1);
      end
      END_LONG_CUT: begin
        push_word($urandom | 32'h8000_0000);
        push_word(TYPE_IDAT);
        repeat ($urandom_range(1, 6)) chunk_bytes.push_back(8'($urandom));
        send_staged(chunk_bytes.size() - 1);
      end
      default: begin
        build_chunk($urandom_range(0, 4), TYPE_IDAT);
        send_staged($urandom_range(0, 7));
      end
    endcase
    in_valid <= 1'b0;

    // Let the checker see the last accept, drain, then watch for strays.
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/pngcw_pkg.sv
rtl/pngcw_core.sv
rtl/pngcw_outq.sv
rtl/png_chunk_walker.sv
tb/sv/png_chunk_walker_checker.sv
tb/sv/png_chunk_walker_tb.sv
